/* sv/btlpm_pkg.sv */
// Shared constants and types for the binary trie longest prefix match block.
`timescale 1ns / 1ps

package btlpm_pkg;

   localparam int NODE_COUNT = 1024;
   localparam int ADDR_BITS  = 32;
   localparam int GW_BITS    = 32;
   localparam int IDX_W      = $clog2(NODE_COUNT);
   localparam int USED_W     = $clog2(NODE_COUNT + 1);
   localparam int DEPTH_W    = $clog2(ADDR_BITS + 1);

   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_LOOKUP  = 1'b1;
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0]   left;
      logic [IDX_W-1:0]   right;
      logic [GW_BITS-1:0] gateway;
   } node_type;

   typedef struct packed {
      logic is_lookup;
      logic at_end;
      logic mask_bit;
      logic slot_zero;
      logic pool_full;
      logic rsp_free;
   } dp_status_type;

   typedef struct packed {
      logic load;
      logic descend;
      logic link;
      logic clear_new;
      logic finish;
      logic write_gw;
      logic full;
   } dp_cmd_type;

endpackage

/* sv/btlpm_if.sv */
// Valid/ready channel interfaces for requests and responses.
`timescale 1ns / 1ps

interface btlpm_req_if;
   logic                            valid;
   logic                            ready;
   logic                            command;
   logic [btlpm_pkg::ADDR_BITS-1:0] address;
   logic [btlpm_pkg::ADDR_BITS-1:0] netmask;
   logic [btlpm_pkg::GW_BITS-1:0]   gateway;

   modport source (output valid, output command, output address, output netmask,
                   output gateway, input ready);
   modport sink (input valid, input command, input address, input netmask,
                 input gateway, output ready);
endinterface

interface btlpm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [btlpm_pkg::GW_BITS-1:0] next_hop;
   logic                          status;

   modport source (output valid, output next_hop, output status, input ready);
   modport sink (input valid, input next_hop, input status, output ready);
endinterface

/* sv/btlpm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module btlpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/btlpm_ctrl.sv */
// Controller state machine sequencing trie walks, node allocation and responses.
`timescale 1ns / 1ps

module btlpm_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  btlpm_pkg::dp_status_type status,
   output btlpm_pkg::dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      IDLE,
      WALK,
      ALLOC
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = WALK;
            end
         end
         WALK: begin
            if (status.is_lookup) begin
               if (status.at_end || status.slot_zero) begin
                  if (status.rsp_free) begin
                     cmd.finish = 1'b1;
                     state_in   = IDLE;
                  end
               end else begin
                  cmd.descend = 1'b1;
               end
            end else if (!status.mask_bit || status.at_end) begin
               if (status.rsp_free) begin
                  cmd.finish   = 1'b1;
                  cmd.write_gw = 1'b1;
                  state_in     = IDLE;
               end
            end else if (status.slot_zero) begin
               if (status.pool_full) begin
                  if (status.rsp_free) begin
                     cmd.finish = 1'b1;
                     cmd.full   = 1'b1;
                     state_in   = IDLE;
                  end
               end else begin
                  cmd.link = 1'b1;
                  state_in = ALLOC;
               end
            end else begin
               cmd.descend = 1'b1;
            end
         end
         ALLOC: begin
            cmd.clear_new = 1'b1;
            state_in      = WALK;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

endmodule

/* sv/btlpm_dpath.sv */
// Datapath: request registers, root node, node pool RAM, walk pointer and response register.
`timescale 1ns / 1ps

module btlpm_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_command,
   input  logic [btlpm_pkg::ADDR_BITS-1:0] req_address,
   input  logic [btlpm_pkg::ADDR_BITS-1:0] req_netmask,
   input  logic [btlpm_pkg::GW_BITS-1:0]   req_gateway,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic [btlpm_pkg::GW_BITS-1:0]   rsp_next_hop,
   output logic                            rsp_status,
   input  btlpm_pkg::dp_cmd_type           cmd,
   output btlpm_pkg::dp_status_type        status
);

   logic                              lookup_ff;
   logic [btlpm_pkg::ADDR_BITS-1:0]   addr_ff;
   logic [btlpm_pkg::ADDR_BITS-1:0]   mask_ff;
   logic [btlpm_pkg::GW_BITS-1:0]     gw_ff;
   logic [btlpm_pkg::DEPTH_W-1:0]     depth_ff;
   logic [btlpm_pkg::IDX_W-1:0]       cur_idx_ff;
   logic                              fresh_ff;
   logic [btlpm_pkg::GW_BITS-1:0]     best_ff;
   logic [btlpm_pkg::USED_W-1:0]      used_ff;
   btlpm_pkg::node_type               root_ff;
   logic                              rsp_valid_ff;
   logic [btlpm_pkg::GW_BITS-1:0]     rsp_hop_ff;
   logic                              rsp_status_ff;

   btlpm_pkg::node_type               ram_rd_word;
   btlpm_pkg::node_type               word;
   btlpm_pkg::node_type               wr_word;
   logic                              node_wr;
   logic                              addr_bit;
   logic [btlpm_pkg::IDX_W-1:0]       slot;
   logic [btlpm_pkg::GW_BITS-1:0]     hop_now;
   logic                              cur_is_root;

   assign cur_is_root = (cur_idx_ff == '0);
   assign word        = fresh_ff ? '0 : (cur_is_root ? root_ff : ram_rd_word);
   assign addr_bit    = addr_ff[btlpm_pkg::ADDR_BITS-1];
   assign slot        = addr_bit ? word.right : word.left;
   assign hop_now     = (word.gateway != '0) ? word.gateway : best_ff;

   always_comb begin
      wr_word = word;
      node_wr = 1'b0;
      if (cmd.link) begin
         node_wr = 1'b1;
         if (addr_bit) begin
            wr_word.right = used_ff[btlpm_pkg::IDX_W-1:0];
         end else begin
            wr_word.left = used_ff[btlpm_pkg::IDX_W-1:0];
         end
      end else if (cmd.clear_new) begin
         node_wr = 1'b1;
         wr_word = '0;
      end else if (cmd.finish && cmd.write_gw) begin
         node_wr         = 1'b1;
         wr_word.gateway = gw_ff;
      end
   end

   btlpm_ram #(
      .WIDTH($bits(btlpm_pkg::node_type)),
      .DEPTH(btlpm_pkg::NODE_COUNT)
   ) u_node_ram (
      .clock  (clock),
      .wr_en  (node_wr && !cur_is_root),
      .wr_addr(cur_idx_ff),
      .wr_data(wr_word),
      .rd_en  (cmd.descend),
      .rd_addr(slot),
      .rd_data(ram_rd_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= btlpm_pkg::USED_W'(1);
         root_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.link) begin
            used_ff <= used_ff + btlpm_pkg::USED_W'(1);
         end
         if (node_wr && cur_is_root) begin
            root_ff <= wr_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lookup_ff  <= (req_command == btlpm_pkg::CMD_LOOKUP);
         addr_ff    <= req_address;
         mask_ff    <= req_netmask;
         gw_ff      <= req_gateway;
         depth_ff   <= '0;
         cur_idx_ff <= '0;
         fresh_ff   <= 1'b0;
         best_ff    <= '0;
      end
      if (cmd.descend || cmd.link) begin
         addr_ff  <= addr_ff << 1;
         mask_ff  <= mask_ff << 1;
         depth_ff <= depth_ff + btlpm_pkg::DEPTH_W'(1);
      end
      if (cmd.descend) begin
         cur_idx_ff <= slot;
         fresh_ff   <= 1'b0;
         best_ff    <= hop_now;
      end
      if (cmd.link) begin
         cur_idx_ff <= used_ff[btlpm_pkg::IDX_W-1:0];
         fresh_ff   <= 1'b1;
      end
      if (cmd.finish) begin
         rsp_hop_ff    <= lookup_ff ? hop_now : '0;
         rsp_status_ff <= cmd.full ? btlpm_pkg::STATUS_FULL : btlpm_pkg::STATUS_DONE;
      end
   end

   assign status.is_lookup = lookup_ff;
   assign status.at_end    = (depth_ff == btlpm_pkg::DEPTH_W'(btlpm_pkg::ADDR_BITS));
   assign status.mask_bit  = mask_ff[btlpm_pkg::ADDR_BITS-1];
   assign status.slot_zero = (slot == '0);
   assign status.pool_full = (used_ff == btlpm_pkg::USED_W'(btlpm_pkg::NODE_COUNT));
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_next_hop = rsp_hop_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

/* sv/binary_trie_longest_prefix_match.sv */
// Top level: IPv4 route table as a binary trie with longest prefix match lookup.
//
// req_ch carries one transaction per insert or lookup: command (0 insert, 1 lookup),
// address, netmask and gateway. rsp_ch returns exactly one transaction per request:
// next_hop (lookup result, 0 for insert or no match) and status (1 if an insert
// ran out of trie nodes).
// req_ch.ready is high while the walker is idle. After acceptance the walker visits
// one trie level per cycle, limited by the single registered read port of the node
// RAM: up to 33 levels, and an insert passes through ALLOC for every node it creates.
// The walker returns to idle at the same clock edge that loads the response register,
// and a new request is accepted only while it is idle, not during a walk. The response
// sits in an output register and the next request is accepted while it waits.
// If rsp_ch.ready is low and the output register is full, the walker holds on its
// last level until the register frees up.
// Reset empties the table (root only, no routes); allocated nodes are
// cleared as they are created, so no memory clearing pass is needed.
`timescale 1ns / 1ps

module binary_trie_longest_prefix_match (
   input logic           clock,
   input logic           reset,
   btlpm_req_if.sink     req_ch,
   btlpm_rsp_if.source   rsp_ch
);

   btlpm_pkg::dp_cmd_type    cmd;
   btlpm_pkg::dp_status_type status;

   btlpm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .status   (status),
      .cmd      (cmd)
   );

   btlpm_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_command (req_ch.command),
      .req_address (req_ch.address),
      .req_netmask (req_ch.netmask),
      .req_gateway (req_ch.gateway),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_next_hop(rsp_ch.next_hop),
      .rsp_status  (rsp_ch.status),
      .cmd         (cmd),
      .status      (status)
   );

   a_descend_has_child: assert property (@(posedge clock) disable iff (reset)
      cmd.descend |-> !status.slot_zero && !status.at_end)
      else $error("descend without a child node");

   a_link_has_room: assert property (@(posedge clock) disable iff (reset)
      cmd.link |-> !status.pool_full && status.slot_zero && !status.is_lookup)
      else $error("node allocated from a full pool or over an existing child");

   a_link_then_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.link |=> cmd.clear_new)
      else $error("new node not cleared after link");

   a_full_only_insert: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && cmd.full |-> status.pool_full && !status.is_lookup)
      else $error("full status reported with free nodes");

endmodule
